// ===== rtl/gls_pkg.sv =====
package gls_pkg;

    localparam int unsigned PIX_W          = 9;
    localparam int unsigned SIZE_W         = 10;
    localparam int unsigned RAD_W          = 13;
    localparam int unsigned GRAY_W         = 8;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 16;

    localparam int unsigned MAX_IMAGE_SIZE = 512;
    localparam int unsigned FRACTION_BITS  = 4;

    // offsets from the centre are in half pixels
    localparam int unsigned OFS_W          = PIX_W + 2;
    localparam int unsigned SQ_W           = 2 * OFS_W - 2;
    localparam int unsigned SUM_W          = SQ_W + 1;
    localparam int unsigned RADICAND_W     = SUM_W + 2 * FRACTION_BITS - 2;
    localparam int unsigned ROOT_W         = (RADICAND_W + 1) / 2;

    localparam int unsigned GLOW_SCALE     = 255;
    localparam int unsigned GLOW_DIV       = 100;
    localparam int unsigned NUM_W          = SIZE_W + 8 + FRACTION_BITS - 1;
    localparam int unsigned DEN_W          = RAD_W + 7;
    localparam int unsigned CMP_W          = DEN_W + GRAY_W;
    localparam logic [GRAY_W-1:0] GRAY_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_INNER_RADIUS = 3'd2,
        REG_OUTER_RADIUS = 3'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [SIZE_W-1:0] image_width;
        logic [SIZE_W-1:0] image_height;
        logic [RAD_W-1:0]  inner_radius;
        logic [RAD_W-1:0]  outer_radius;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } t_pix;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] lim;
        lim = SIZE_W'(MAX_IMAGE_SIZE);
        if (MAX_IMAGE_SIZE < (1 << SIZE_W) && s > lim) begin
            return lim;
        end
        return s;
    endfunction

endpackage

// ===== rtl/gls_if.sv =====
interface gls_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [gls_pkg::PIX_W-1:0] pixel_x;
    logic [gls_pkg::PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface gls_gray_if;
    logic                       valid;
    logic                       ready;
    logic [gls_pkg::GRAY_W-1:0] gray_level;

    modport source (output valid, output gray_level, input ready);
    modport sink (input valid, input gray_level, output ready);
endinterface

interface gls_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [gls_pkg::CFG_IDX_W-1:0]  index;
    logic [gls_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/gls_geom.sv =====
module gls_geom (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gls_pkg::t_cfg                    i_cfg,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  gls_pkg::t_pix                    i_pix,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [gls_pkg::RADICAND_W-1:0]   o_radicand
);

    localparam int unsigned NSTG   = 3;
    localparam int unsigned WIDE_W = gls_pkg::SUM_W + 2 * gls_pkg::FRACTION_BITS;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;

    logic signed [gls_pkg::OFS_W-1:0]   r_dx, r_dy;
    logic signed [gls_pkg::OFS_W-1:0]   n_dx, n_dy;
    logic        [gls_pkg::SQ_W-1:0]    r_dx2, r_dy2;
    logic signed [2*gls_pkg::OFS_W-1:0] p_x, p_y;
    logic        [gls_pkg::SUM_W-1:0]   sum;
    logic        [WIDE_W-1:0]           wide;
    logic        [gls_pkg::RADICAND_W-1:0] r_rad;
    logic        [gls_pkg::SIZE_W-1:0]  w_cl, h_cl;
    logic        [gls_pkg::OFS_W:0]     ex_px, ex_py, ex_w, ex_h;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = 0; k < NSTG - 1; k++) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end
    assign o_ready = rdy[0];

    // centre offsets in half pixels: 2*p - size
    assign w_cl  = gls_pkg::clamp_size(i_cfg.image_width);
    assign h_cl  = gls_pkg::clamp_size(i_cfg.image_height);
    assign ex_px = (gls_pkg::OFS_W + 1)'(i_pix.pixel_x) << 1;
    assign ex_py = (gls_pkg::OFS_W + 1)'(i_pix.pixel_y) << 1;
    assign ex_w  = (gls_pkg::OFS_W + 1)'(w_cl);
    assign ex_h  = (gls_pkg::OFS_W + 1)'(h_cl);
    assign n_dx  = gls_pkg::OFS_W'(ex_px - ex_w);
    assign n_dy  = gls_pkg::OFS_W'(ex_py - ex_h);

    assign p_x  = r_dx * r_dx;
    assign p_y  = r_dy * r_dy;

    assign sum  = gls_pkg::SUM_W'(r_dx2) + gls_pkg::SUM_W'(r_dy2);
    assign wide = (WIDE_W'(sum) << (2 * gls_pkg::FRACTION_BITS)) >> 2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (rdy[1] && r_vld[0]) begin
            r_dx2 <= p_x[gls_pkg::SQ_W-1:0];
            r_dy2 <= p_y[gls_pkg::SQ_W-1:0];
        end
        if (rdy[2] && r_vld[1]) begin
            r_rad <= wide[gls_pkg::RADICAND_W-1:0];
        end
    end

    assign o_valid    = r_vld[NSTG-1];
    assign o_radicand = r_rad;

endmodule

// ===== rtl/gls_sqrt.sv =====
module gls_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [gls_pkg::RADICAND_W-1:0]   i_radicand,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [gls_pkg::ROOT_W-1:0]       o_root
);

    localparam int unsigned RW    = gls_pkg::ROOT_W;
    localparam int unsigned PAD_W = 2 * RW;
    localparam int unsigned REM_W = RW + 3;
    localparam int unsigned SPS   = 4;
    localparam int unsigned NSTG  = (RW + SPS - 1) / SPS;

    typedef struct packed {
        logic [PAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [RW-1:0]    root;
    } t_sqrt_st;

    // one root bit: bring down two radicand bits, try (root << 2) | 1
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st s);
        t_sqrt_st         o;
        logic [REM_W-1:0] rem2;
        logic [REM_W-1:0] trial;
        rem2  = {s.rem[REM_W-3:0], s.rad[PAD_W-1 -: 2]};
        trial = REM_W'({s.root, 2'b01});
        o.rad = s.rad << 2;
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {s.root[RW-2:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {s.root[RW-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;
    t_sqrt_st        r_st [NSTG];
    t_sqrt_st        n_st [NSTG];
    t_sqrt_st        first;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = 0; k < NSTG - 1; k++) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end
    assign o_ready = rdy[0];

    assign first.rad  = PAD_W'(i_radicand);
    assign first.rem  = '0;
    assign first.root = '0;

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        t_sqrt_st st_in;
        logic     vld_in;

        if (s == 0) begin : g_head
            assign st_in  = first;
            assign vld_in = i_valid;
        end else begin : g_body
            assign st_in  = r_st[s-1];
            assign vld_in = r_vld[s-1];
        end

        always_comb begin
            t_sqrt_st cur;
            cur = st_in;
            for (int j = 0; j < SPS; j++) begin
                if (s * SPS + j < RW) begin
                    cur = sqrt_step(cur);
                end
            end
            n_st[s] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (rdy[s] && vld_in) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_root  = r_st[NSTG-1].root;

endmodule

// ===== rtl/gls_shade.sv =====
module gls_shade (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gls_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gls_pkg::ROOT_W-1:0]    i_dist,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [gls_pkg::GRAY_W-1:0]    o_gray
);

    localparam int unsigned NSTG = 3;
    localparam int unsigned GW   = gls_pkg::GRAY_W;
    localparam int unsigned HALF = GW / 2;

    typedef struct packed {
        logic                     glow;
        logic                     ring;
        logic                     sat;
        logic [gls_pkg::CMP_W-1:0] rem;
        logic [gls_pkg::DEN_W-1:0] den;
        logic [GW-1:0]            q;
    } t_div_st;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;

    logic [gls_pkg::ROOT_W-1:0] inner_x, outer_x;
    logic [gls_pkg::RAD_W-1:0]  diff;
    logic [gls_pkg::SIZE_W-1:0] h_cl;
    t_div_st                    n_d0, r_d0, n_d1, r_d1;
    logic [GW-1:0]              n_gray, r_gray;

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = 0; k < NSTG - 1; k++) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end
    assign o_ready = rdy[0];

    // classify against the radii and set up num / den of the glow
    assign inner_x = gls_pkg::ROOT_W'(i_cfg.inner_radius);
    assign outer_x = gls_pkg::ROOT_W'(i_cfg.outer_radius);
    assign diff    = gls_pkg::RAD_W'(inner_x - i_dist);
    assign h_cl    = gls_pkg::clamp_size(i_cfg.image_height);

    always_comb begin
        logic [gls_pkg::NUM_W-1:0] num;
        num         = (gls_pkg::NUM_W'(h_cl) * gls_pkg::NUM_W'(gls_pkg::GLOW_SCALE))
                      << gls_pkg::FRACTION_BITS;
        n_d0.glow   = i_dist < inner_x;
        n_d0.ring   = (i_dist == inner_x) || (i_dist < outer_x);
        n_d0.sat    = 1'b0;
        n_d0.rem    = gls_pkg::CMP_W'(num);
        n_d0.den    = gls_pkg::DEN_W'(diff) * gls_pkg::DEN_W'(gls_pkg::GLOW_DIV);
        n_d0.q      = '0;
    end

    // saturation test and the upper quotient bits
    always_comb begin
        logic [gls_pkg::CMP_W-1:0] dsh;
        n_d1     = r_d0;
        n_d1.sat = r_d0.rem >= (gls_pkg::CMP_W'(r_d0.den) << GW);
        for (int k = GW - 1; k >= int'(HALF); k--) begin
            dsh = gls_pkg::CMP_W'(r_d0.den) << k;
            if (n_d1.rem >= dsh) begin
                n_d1.rem  = n_d1.rem - dsh;
                n_d1.q[k] = 1'b1;
            end
        end
    end

    // lower quotient bits and the choice of glow, ring or black
    always_comb begin
        logic [gls_pkg::CMP_W-1:0] dsh;
        t_div_st                   cur;
        cur = r_d1;
        for (int k = int'(HALF) - 1; k >= 0; k--) begin
            dsh = gls_pkg::CMP_W'(r_d1.den) << k;
            if (cur.rem >= dsh) begin
                cur.rem  = cur.rem - dsh;
                cur.q[k] = 1'b1;
            end
        end
        if (cur.glow) begin
            n_gray = cur.sat ? gls_pkg::GRAY_MAX : cur.q;
        end else if (cur.ring) begin
            n_gray = gls_pkg::GRAY_MAX;
        end else begin
            n_gray = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_d0 <= n_d0;
        end
        if (rdy[1] && r_vld[0]) begin
            r_d1 <= n_d1;
        end
        if (rdy[2] && r_vld[1]) begin
            r_gray <= n_gray;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_gray  = r_gray;

endmodule

// ===== rtl/ring_glow_pixel_shader_top.sv =====
// channel   dir  handshake     payload
// i_pix     in   valid/ready   pixel_x[8:0], pixel_y[8:0]
// o_gray    out  valid/ready   gray_level[7:0]
// i_cfg     in   valid/ready   index[2:0], data[15:0] (always ready)
//
// one item per clock sustained while o_gray is ready, in pipeline stages:
// 3 for offsets, squares and radicand, 4 for the root (four root bits a
// stage, two in last), 3 for glow (set-up, sat + upper 4 bits, lower 4).
// reset empties every stage and loads the register defaults.
// on a stall each stage holds only while the one after it is full, so
// bubbles close up and o_gray can hold an item while i_pix still takes one.
module ring_glow_pixel_shader_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gls_pixel_if.sink   i_pix,
    gls_gray_if.source  o_gray,
    gls_cfg_if.sink     i_cfg
);

    logic [gls_pkg::SIZE_W-1:0] r_image_width;
    logic [gls_pkg::SIZE_W-1:0] r_image_height;
    logic [gls_pkg::RAD_W-1:0]  r_inner_radius;
    logic [gls_pkg::RAD_W-1:0]  r_outer_radius;
    gls_pkg::t_cfg              cfg;
    gls_pkg::t_pix              pix;

    logic                               geo_valid, geo_ready;
    logic [gls_pkg::RADICAND_W-1:0]     geo_rad;
    logic                               sq_valid, sq_ready;
    logic [gls_pkg::ROOT_W-1:0]         sq_root;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= gls_pkg::SIZE_W'(350);
            r_image_height <= gls_pkg::SIZE_W'(350);
            r_inner_radius <= gls_pkg::RAD_W'(480);
            r_outer_radius <= gls_pkg::RAD_W'(640);
        end else if (i_cfg.valid) begin
            unique case (gls_pkg::t_cfg_reg'(i_cfg.index))
                gls_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data[gls_pkg::SIZE_W-1:0];
                gls_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg.data[gls_pkg::SIZE_W-1:0];
                gls_pkg::REG_INNER_RADIUS: r_inner_radius <= i_cfg.data[gls_pkg::RAD_W-1:0];
                gls_pkg::REG_OUTER_RADIUS: r_outer_radius <= i_cfg.data[gls_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.image_width  = r_image_width;
    assign cfg.image_height = r_image_height;
    assign cfg.inner_radius = r_inner_radius;
    assign cfg.outer_radius = r_outer_radius;

    assign pix.pixel_x = i_pix.pixel_x;
    assign pix.pixel_y = i_pix.pixel_y;

    gls_geom u_geom (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (i_pix.valid),
        .o_ready    (i_pix.ready),
        .i_pix      (pix),
        .o_valid    (geo_valid),
        .i_ready    (geo_ready),
        .o_radicand (geo_rad)
    );

    gls_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (geo_valid),
        .o_ready    (geo_ready),
        .i_radicand (geo_rad),
        .o_valid    (sq_valid),
        .i_ready    (sq_ready),
        .o_root     (sq_root)
    );

    gls_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (sq_valid),
        .o_ready (sq_ready),
        .i_dist  (sq_root),
        .o_valid (o_gray.valid),
        .i_ready (o_gray.ready),
        .o_gray  (o_gray.gray_level)
    );

    // with the sink taking items every stage can move, so input is open
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gray.ready |-> i_pix.ready)
        else $error("input stalled although output is ready");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_gray.valid)
        else $error("output valid right after reset");

    // no point lies inside a zero inner radius, so only ring or black
    a_no_glow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_gray.valid && r_inner_radius == '0 |->
            o_gray.gray_level == '0 || o_gray.gray_level == gls_pkg::GRAY_MAX)
        else $error("glow level with zero inner radius");

endmodule
